### rtl/html_body_text_extractor_assert.svh
// Assertion macros used by the top-level RTL file of the HTML body text extractor.
`ifndef HTML_BODY_TEXT_EXTRACTOR_ASSERT_SVH
`define HTML_BODY_TEXT_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define HTX_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("html body text extractor: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define HTX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("html body text extractor: next-cycle check failed");

`endif

### rtl/htx_pkg.sv
// Shared types and constants of the HTML body text extractor.
package htx_pkg;

    localparam int COUNT_W = 24;  // byte index and emitted count, 16 to 32
    localparam int CFG_W   = 24;  // configuration register width
    localparam int CMP_W   = 32;  // common width for limit compares

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [CFG_W-1:0] TEXT_LIMIT_RST   = CFG_W'(20000);
    localparam logic [CFG_W-1:0] POSITION_CAP_RST = CFG_W'(1000000);

    typedef enum logic [0:0] {
        REG_TEXT_LIMIT   = 1'b0,
        REG_POSITION_CAP = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] doc_byte;
        logic       doc_last;
    } t_in_item;

    typedef struct packed {
        logic       end_of_text;
        logic       char_valid;
        logic [7:0] out_char;
    } t_result;

endpackage

### rtl/html_body_text_extractor.sv
// Top level of the HTML body text extractor: stages, config registers, checks.
//
//  Channel   Dir  Handshake                     Payload
//  --------  ---  ----------------------------  --------------------------------
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata = doc_byte, tlast = doc_last
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata = out_char,
//                                                tuser = char_valid,
//                                                tlast = end_of_text
//  cfg       in   i_cfg_wr_en (no wait)         i_cfg_addr, i_cfg_wdata
//
//  One document byte per cycle, sustained while m_axis does not stall; the per-byte
//  matcher logic sits between the input register and the output register.
//  A byte's result goes from the input register through the output register to m_axis.
//  Reset (i_rst_n low, synchronous) empties both stages, clears the parser
//  state and loads the register defaults (text_limit 20000, position_cap
//  1000000). A stall on m_axis holds the output register; the input register
//  still takes one more byte, then backpressure reaches s_axis_tready.
module html_body_text_extractor import htx_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration write port
    input  logic             i_cfg_wr_en,
    input  logic             i_cfg_addr,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    // byte stream in
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [7:0] doc_byte
    input  logic             s_axis_tlast,   // doc_last
    // text stream out
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] out_char
    output logic             m_axis_tuser,   // [0] char_valid
    output logic             m_axis_tlast    // end_of_text
);

    `include "html_body_text_extractor_assert.svh"

    logic [CFG_W-1:0] r_text_limit;
    logic [CFG_W-1:0] r_position_cap;

    t_in_item in_item;
    t_in_item stage_item;
    logic     stage_valid;
    logic     out_free;
    logic     advance;
    logic     res_valid;
    t_result  res;
    t_result  out_res;

    // The user must write the registers only while the block is idle; the block does not enforce it (no write guard).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_limit   <= TEXT_LIMIT_RST;
            r_position_cap <= POSITION_CAP_RST;
        end else if (i_cfg_wr_en) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_TEXT_LIMIT:   r_text_limit   <= i_cfg_wdata;
                REG_POSITION_CAP: r_position_cap <= i_cfg_wdata;
                default:          r_text_limit   <= r_text_limit;
            endcase
        end
    end

    assign in_item.doc_byte = s_axis_tdata;
    assign in_item.doc_last = s_axis_tlast;

    // Advance the held byte through the parser when its result has a place to go.
    assign advance = stage_valid && out_free;

    htx_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tvalid  (s_axis_tvalid),
        .o_tready  (s_axis_tready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    htx_parse_core u_parse_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (advance),
        .i_item         (stage_item),
        .i_text_limit   (r_text_limit),
        .i_position_cap (r_position_cap),
        .o_res_valid    (res_valid),
        .o_result       (res)
    );

    htx_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (advance),
        .i_res_valid (res_valid),
        .i_result    (res),
        .i_tready    (m_axis_tready),
        .o_tvalid    (m_axis_tvalid),
        .o_result    (out_res),
        .o_free      (out_free)
    );

    assign m_axis_tdata = out_res.out_char;
    assign m_axis_tuser = out_res.char_valid;
    assign m_axis_tlast = out_res.end_of_text;

    // A result without a character is only ever the end marker.
    `HTX_ASSERT_SAME(a_nochar_is_end, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tuser, m_axis_tlast)
    // A result without a character carries a zero byte.
    `HTX_ASSERT_SAME(a_nochar_zero, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 8'h00)
    // With both stages full and the output stalled, the input side must stall.
    `HTX_ASSERT_SAME(a_full_stalls_input, i_clk, i_rst_n,
        stage_valid && m_axis_tvalid && !m_axis_tready, !s_axis_tready)

endmodule

### rtl/htx_in_stage.sv
// Input register stage: capture one byte transaction and hold it for the parser.
module htx_in_stage import htx_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_tvalid,
    output logic     o_tready,
    input  t_in_item i_item,
    input  logic     i_advance,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;

    // Take a new byte whenever the register is empty or drains this cycle.
    assign o_tready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_tready) begin
            r_valid <= i_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tvalid && o_tready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### rtl/htx_parse_core.sv
// Parser core: document state, tag matchers and the per-byte next-state logic.
module htx_parse_core import htx_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  t_in_item         i_item,
    input  logic [CFG_W-1:0] i_text_limit,
    input  logic [CFG_W-1:0] i_position_cap,
    output logic             o_res_valid,
    output t_result          o_result
);

    typedef enum logic [2:0] {
        MODE_SEEK    = 3'd0,
        MODE_RESTART = 3'd1,
        MODE_TAG     = 3'd2,
        MODE_COPY    = 3'd3,
        MODE_CLASS   = 3'd4,
        MODE_STYLE   = 3'd5,
        MODE_SCRIPT  = 3'd6,
        MODE_DONE    = 3'd7
    } t_mode;

    typedef struct packed {
        logic       done;
        logic [3:0] mi;
    } t_seek;

    localparam logic [7:0] CH_LT    = "<";
    localparam logic [7:0] CH_GT    = ">";
    localparam logic [7:0] CH_SPACE = " ";

    localparam logic [3:0] BODY_LEN   = 4'd5;
    localparam logic [3:0] STYLE_LEN  = 4'd8;
    localparam logic [3:0] SCRIPT_LEN = 4'd9;

    localparam logic [7:0] BODY_PAT [5] = '{"<", "b", "o", "d", "y"};
    localparam logic [7:0] STYLE_END [8] = '{"<", "/", "s", "t", "y", "l", "e", ">"};
    localparam logic [7:0] SCRIPT_END [9] =
        '{"<", "/", "s", "c", "r", "i", "p", "t", ">"};

    // Tag prefixes checked after a '<' in text: style, script, /body, /html.
    localparam logic [7:0] CAND_PAT [4][7] = '{
        '{"<", "s", "t", "y", "l", "e", 8'h00},
        '{"<", "s", "c", "r", "i", "p", "t"},
        '{"<", "/", "b", "o", "d", "y", 8'h00},
        '{"<", "/", "h", "t", "m", "l", 8'h00}
    };
    localparam logic [3:0] CAND_LEN [4] = '{4'd6, 4'd7, 4'd6, 4'd6};

    t_mode              r_mode,  n_mode;
    logic [3:0]         r_mi,    n_mi;
    logic [3:0]         r_cand,  n_cand;
    logic [COUNT_W-1:0] r_bidx,  n_bidx;
    logic [COUNT_W-1:0] r_emit,  n_emit;
    logic               r_end,   n_end;

    logic [7:0]         b;
    logic [3:0]         mi_inc;
    logic [3:0]         hit;
    logic [3:0]         done;
    logic               pat_hit;
    t_seek              sk;
    logic               restart_req;
    logic [COUNT_W-1:0] restart_pos;
    logic               stop;
    logic               ch_valid;
    logic [7:0]         ch;

    // One step of a fixed-pattern search; pat_ok says the current byte matches.
    function automatic t_seek seek_step(input logic [3:0] mi, input logic pat_ok,
                                        input logic [3:0] len, input logic [7:0] bt);
        t_seek res;
        res.done = 1'b0;
        if (pat_ok) begin
            res.mi = mi + 4'd1;
            if (res.mi == len) begin
                res.done = 1'b1;
                res.mi   = 4'd0;
            end
        end else begin
            res.mi = (bt == CH_LT) ? 4'd1 : 4'd0;
        end
        return res;
    endfunction

    function automatic logic restart_ok(input logic [COUNT_W-1:0] pos,
                                        input logic [COUNT_W-1:0] cnt,
                                        input logic [CFG_W-1:0]   cap,
                                        input logic [CFG_W-1:0]   lim);
        return (CMP_W'(pos) < CMP_W'(cap)) && (CMP_W'(cnt) < CMP_W'(lim));
    endfunction

    assign b      = i_item.doc_byte;
    assign mi_inc = r_mi + 4'd1;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            hit[k]  = r_cand[k] && (r_mi < CAND_LEN[k]) && (CAND_PAT[k][r_mi[2:0]] == b);
            done[k] = hit[k] && (CAND_LEN[k] == mi_inc);
        end
    end

    always_comb begin
        n_mode      = r_mode;
        n_mi        = r_mi;
        n_cand      = r_cand;
        n_bidx      = r_bidx;
        n_emit      = r_emit;
        n_end       = r_end;
        restart_req = 1'b0;
        restart_pos = r_bidx;
        stop        = 1'b0;
        ch_valid    = 1'b0;
        ch          = 8'h00;
        pat_hit     = 1'b0;
        sk          = '0;
        o_res_valid = 1'b0;

        if (!r_end) begin
            unique case (r_mode)
                MODE_SEEK: begin
                    pat_hit = (r_mi < BODY_LEN) && (BODY_PAT[r_mi[2:0]] == b);
                    sk      = seek_step(r_mi, pat_hit, BODY_LEN, b);
                    n_mi    = sk.mi;
                    restart_req = sk.done;
                end
                MODE_RESTART: begin
                    restart_req = 1'b1;
                end
                MODE_TAG: begin
                    n_mode = (b == CH_GT) ? MODE_COPY : MODE_TAG;
                    if (b == CH_GT) begin
                        ch_valid = 1'b1;
                        ch       = CH_SPACE;
                    end
                end
                MODE_COPY: begin
                    if (b == CH_LT) begin
                        n_mode = MODE_CLASS;
                        n_mi   = 4'd1;
                        n_cand = 4'hF;
                    end else begin
                        ch_valid = 1'b1;
                        ch       = b;
                    end
                end
                MODE_CLASS: begin
                    if (hit == 4'h0) begin
                        // Unknown tag: restart at its '<'.
                        restart_req = 1'b1;
                        restart_pos = (r_bidx == COUNT_MAX) ? COUNT_MAX
                                                            : r_bidx - COUNT_W'(r_mi);
                        n_mi   = 4'd0;
                        n_cand = 4'h0;
                    end else begin
                        n_cand = hit;
                        n_mi   = mi_inc;
                        if (done[0]) begin
                            n_mode = MODE_STYLE;
                            n_mi   = 4'd0;
                            n_cand = 4'h0;
                        end else if (done[1]) begin
                            n_mode = MODE_SCRIPT;
                            n_mi   = 4'd0;
                            n_cand = 4'h0;
                        end else if (done[2] || done[3]) begin
                            stop   = 1'b1;
                            n_mi   = 4'd0;
                            n_cand = 4'h0;
                        end
                    end
                end
                MODE_STYLE: begin
                    pat_hit = (r_mi < STYLE_LEN) && (STYLE_END[r_mi[2:0]] == b);
                    sk      = seek_step(r_mi, pat_hit, STYLE_LEN, b);
                    n_mi    = sk.mi;
                    if (sk.done) begin
                        n_mode = MODE_RESTART;
                    end
                end
                MODE_SCRIPT: begin
                    pat_hit = (r_mi < SCRIPT_LEN) && (SCRIPT_END[r_mi] == b);
                    sk      = seek_step(r_mi, pat_hit, SCRIPT_LEN, b);
                    n_mi    = sk.mi;
                    if (sk.done) begin
                        n_mode = MODE_RESTART;
                    end
                end
                MODE_DONE: begin
                end
            endcase

            // Loop restart: check limits, then treat the byte as a tag byte.
            if (restart_req) begin
                if (!restart_ok(restart_pos, r_emit, i_position_cap, i_text_limit)) begin
                    stop = 1'b1;
                end else if (b == CH_GT) begin
                    ch_valid = 1'b1;
                    ch       = CH_SPACE;
                    n_mode   = MODE_COPY;
                end else begin
                    n_mode = MODE_TAG;
                end
            end

            if (ch_valid && (r_emit != COUNT_MAX)) begin
                n_emit = r_emit + COUNT_W'(1);
            end
            if (r_bidx != COUNT_MAX) begin
                n_bidx = r_bidx + COUNT_W'(1);
            end
            if (stop) begin
                n_end  = 1'b1;
                n_mode = MODE_DONE;
            end
            o_res_valid = stop || i_item.doc_last || ch_valid;
        end

        // Final byte: return the document state to reset.
        if (i_item.doc_last) begin
            n_mode = MODE_SEEK;
            n_mi   = 4'd0;
            n_cand = 4'h0;
            n_bidx = '0;
            n_emit = '0;
            n_end  = 1'b0;
        end
    end

    assign o_result.end_of_text = stop || i_item.doc_last;
    assign o_result.char_valid  = ch_valid;
    assign o_result.out_char    = ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_SEEK;
            r_mi   <= 4'd0;
            r_cand <= 4'h0;
            r_bidx <= '0;
            r_emit <= '0;
            r_end  <= 1'b0;
        end else if (i_step) begin
            r_mode <= n_mode;
            r_mi   <= n_mi;
            r_cand <= n_cand;
            r_bidx <= n_bidx;
            r_emit <= n_emit;
            r_end  <= n_end;
        end
    end

endmodule

### rtl/htx_out_stage.sv
// Output register: hold one result until the downstream side takes it.
module htx_out_stage import htx_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  logic    i_res_valid,
    input  t_result i_result,
    input  logic    i_tready,
    output logic    o_tvalid,
    output t_result o_result,
    output logic    o_free
);

    logic    r_valid;
    t_result r_result;

    // Free when empty or when the held result leaves this cycle.
    assign o_free = !r_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_res_valid;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_res_valid) begin
            r_result <= i_result;
        end
    end

    assign o_tvalid = r_valid;
    assign o_result = r_result;

endmodule

### tb/htx_text_checker.sv
`timescale 1ns / 1ps
// Checker of the HTML body text extractor: follows both streams, predicts the text, compares.
module htx_text_checker import htx_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic             i_cfg_addr,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_byte_valid,
    input  logic             i_byte_ready,
    input  logic [7:0]       i_byte,
    input  logic             i_byte_last,
    input  logic             i_text_valid,
    input  logic             i_text_ready,
    input  logic [7:0]       i_text_char,
    input  logic             i_text_user,
    input  logic             i_text_last,
    output int               o_fail_cnt,
    output int               o_pending,
    output int               o_char_cnt,
    output int               o_end_cnt
);

    typedef enum logic [2:0] {
        PM_SEEK, PM_RESTART, PM_TAG, PM_COPY, PM_CLASS, PM_STYLE, PM_SCRIPT, PM_DONE
    } t_parse_mode;

    localparam logic [7:0] CH_LT    = "<";
    localparam logic [7:0] CH_GT    = ">";
    localparam logic [7:0] CH_SPACE = " ";

    logic [CFG_W-1:0]   text_lim;
    logic [CFG_W-1:0]   pos_cap;
    t_parse_mode        mode;
    logic [3:0]         match_idx;
    logic [3:0]         cands;
    logic [COUNT_W-1:0] byte_idx;
    logic [COUNT_W-1:0] emit_cnt;
    logic               end_done;

    t_result text_due[$];

    // Patterns are packed strings, first character in the highest byte in use.
    function automatic logic [7:0] pat_char(input logic [71:0] pat, input int len,
                                            input int idx);
        return pat[8*(len-1-idx) +: 8];
    endfunction

    function automatic int cand_len(input int k);
        return (k == 1) ? 7 : 6;
    endfunction

    function automatic logic [71:0] cand_pat(input int k);
        case (k)
            0:       return "<style";
            1:       return "<script";
            2:       return "</body";
            default: return "</html";
        endcase
    endfunction

    function automatic bit restart_ok(input logic [COUNT_W-1:0] pos);
        return (pos < pos_cap) && (emit_cnt < text_lim);
    endfunction

    task automatic clear_doc();
        mode      = PM_SEEK;
        match_idx = '0;
        cands     = '0;
        byte_idx  = '0;
        emit_cnt  = '0;
        end_done  = 1'b0;
    endtask

    task automatic count_emit();
        if (emit_cnt != COUNT_MAX) emit_cnt = emit_cnt + COUNT_W'(1);
    endtask

    // Skip to '>' and answer it with one space.
    task automatic close_tag(input logic [7:0] b, inout logic [7:0] ch, inout logic ch_ok);
        if (b == CH_GT) begin
            ch    = CH_SPACE;
            ch_ok = 1'b1;
            count_emit();
            mode  = PM_COPY;
        end else begin
            mode  = PM_TAG;
        end
    endtask

    function automatic bit seek_step(input logic [71:0] pat, input int len,
                                     input logic [7:0] b);
        bit matched;
        bit full;
        matched = 1'b0;
        full    = 1'b0;
        if (int'(match_idx) < len) matched = (pat_char(pat, len, int'(match_idx)) == b);
        if (matched) begin
            match_idx = match_idx + 4'd1;
            if (int'(match_idx) == len) begin
                match_idx = '0;
                full      = 1'b1;
            end
        end else begin
            match_idx = (b == CH_LT) ? 4'd1 : 4'd0;
        end
        return full;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("htx_text_checker: %s: got %02h, want %02h at %0t", what, got, want, $time);
        o_fail_cnt++;
    endtask

    // Run one document byte through the parser copy; queue the text it yields.
    task automatic advance_parser(input logic [7:0] b, input logic last);
        logic [7:0]         ch;
        logic               ch_ok;
        logic               stop;
        logic               found;
        logic [3:0]         hit;
        logic [COUNT_W-1:0] pos;
        t_result            r;
        ch    = '0;
        ch_ok = 1'b0;
        stop  = 1'b0;
        if (end_done) begin
            if (last) clear_doc();
        end else begin
            case (mode)
                PM_SEEK: begin
                    if (seek_step("<body", 5, b)) begin
                        if (!restart_ok(byte_idx)) stop = 1'b1;
                        else close_tag(b, ch, ch_ok);
                    end
                end
                PM_RESTART: begin
                    if (!restart_ok(byte_idx)) stop = 1'b1;
                    else close_tag(b, ch, ch_ok);
                end
                PM_TAG: close_tag(b, ch, ch_ok);
                PM_COPY: begin
                    if (b == CH_LT) begin
                        mode      = PM_CLASS;
                        match_idx = 4'd1;
                        cands     = 4'hF;
                    end else begin
                        ch    = b;
                        ch_ok = 1'b1;
                        count_emit();
                    end
                end
                PM_CLASS: begin
                    hit = '0;
                    for (int k = 0; k < 4; k++)
                        if (cands[k] && int'(match_idx) < cand_len(k))
                            if (pat_char(cand_pat(k), cand_len(k), int'(match_idx)) == b)
                                hit[k] = 1'b1;
                    match_idx = match_idx + 4'd1;
                    if (hit == '0) begin
                        // unknown tag: the loop restarts at its '<'
                        pos = (byte_idx == COUNT_MAX) ? COUNT_MAX
                                : byte_idx - COUNT_W'(match_idx - 4'd1);
                        match_idx = '0;
                        cands     = '0;
                        if (!restart_ok(pos)) stop = 1'b1;
                        else close_tag(b, ch, ch_ok);
                    end else begin
                        cands = hit;
                        found = 1'b0;
                        for (int k = 0; k < 4; k++) begin
                            if (!found && hit[k] && cand_len(k) == int'(match_idx)) begin
                                found     = 1'b1;
                                match_idx = '0;
                                cands     = '0;
                                if (k == 0) mode = PM_STYLE;
                                else if (k == 1) mode = PM_SCRIPT;
                                else stop = 1'b1;
                            end
                        end
                    end
                end
                PM_STYLE:  if (seek_step("</style>", 8, b)) mode = PM_RESTART;
                PM_SCRIPT: if (seek_step("</script>", 9, b)) mode = PM_RESTART;
                default: ;
            endcase

            if (byte_idx != COUNT_MAX) byte_idx = byte_idx + COUNT_W'(1);
            if (stop) begin
                end_done = 1'b1;
                mode     = PM_DONE;
            end
            if (stop || last || ch_ok) begin
                r.out_char    = ch_ok ? ch : 8'h00;
                r.char_valid  = ch_ok;
                r.end_of_text = stop || last;
                text_due = {text_due, r};
            end
            if (last) clear_doc();
        end
    endtask

    task automatic check_text();
        t_result want;
        if (text_due.size() == 0) begin
            report_mismatch("text transaction with nothing expected", i_text_char, 8'h00);
        end else begin
            want = text_due.pop_front();
            if (i_text_char != want.out_char)
                report_mismatch("out_char", i_text_char, want.out_char);
            if (i_text_user != want.char_valid)
                report_mismatch("char_valid", {7'd0, i_text_user}, {7'd0, want.char_valid});
            if (i_text_last != want.end_of_text)
                report_mismatch("end_of_text", {7'd0, i_text_last}, {7'd0, want.end_of_text});
        end
        if (i_text_user) o_char_cnt++;
        if (i_text_last) o_end_cnt++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            text_lim   = TEXT_LIMIT_RST;
            pos_cap    = POSITION_CAP_RST;
            clear_doc();
            text_due.delete();
            o_fail_cnt = 0;
            o_char_cnt = 0;
            o_end_cnt  = 0;
        end else begin
            if (i_cfg_wr_en) begin
                if (t_reg_idx'(i_cfg_addr) == REG_TEXT_LIMIT) text_lim = i_cfg_wdata;
                else pos_cap = i_cfg_wdata;
            end
            // pop before push: a result never leaves in the cycle its byte enters
            if (i_text_valid && i_text_ready) check_text();
            if (i_byte_valid && i_byte_ready) advance_parser(i_byte, i_byte_last);
        end
        o_pending <= text_due.size();
    end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Testbench top of the HTML body text extractor: stimulus, stalls, watchdog and verdict.
module tb;
    import htx_pkg::*;

    localparam int QUIET_LIMIT  = 3000;  // cycles without any transaction before giving up
    localparam int PHASE_BYTES  = 250;   // document bytes per register setting
    localparam int NUM_PHASES   = 7;
    localparam int CALM_FROM    = 300;   // byte window in which neither side idles
    localparam int CALM_TO      = 600;
    localparam int HOLD_AT      = 900;   // byte count that arms the long output stall
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;     // drain time for both register stages plus margin

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic             i_cfg_addr;
    logic [CFG_W-1:0] i_cfg_wdata;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata;
    logic             s_axis_tlast;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [7:0]       m_axis_tdata;
    logic             m_axis_tuser;
    logic             m_axis_tlast;

    int fail_cnt;
    int pending;
    int char_cnt;
    int end_cnt;
    int sent_cnt = 0;
    int quiet_cycles = 0;
    int doc_cnt = 0;

    logic [7:0] doc[$];

    html_body_text_extractor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    htx_text_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_byte_valid (s_axis_tvalid),
        .i_byte_ready (s_axis_tready),
        .i_byte       (s_axis_tdata),
        .i_byte_last  (s_axis_tlast),
        .i_text_valid (m_axis_tvalid),
        .i_text_ready (m_axis_tready),
        .i_text_char  (m_axis_tdata),
        .i_text_user  (m_axis_tuser),
        .i_text_last  (m_axis_tlast),
        .o_fail_cnt   (fail_cnt),
        .o_pending    (pending),
        .o_char_cnt   (char_cnt),
        .o_end_cnt    (end_cnt)
    );

    always #5 i_clk = ~i_clk;

    // Count accepted bytes; stimulus and receiver read this to place their windows.
    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) sent_cnt <= sent_cnt + 1;
    end

    // Watchdog: end the run when neither stream moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: no transaction for %0d cycles", QUIET_LIMIT);
            $display("tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Text receiver: random stalls, a calm window, and one long hold-off while
    // bytes are still offered so the block fills and drops s_axis_tready.
    initial begin
        bit held;
        held = 1'b0;
        m_axis_tready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (!held && sent_cnt >= HOLD_AT && s_axis_tvalid) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (sent_cnt >= CALM_FROM && sent_cnt < CALM_TO) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= 38);
            end
        end
    end

    // Offer one byte, idling first at random outside the calm window; return once taken.
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (!(sent_cnt >= CALM_FROM && sent_cnt < CALM_TO)) begin
            while ($urandom_range(99) < 38) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic send_doc();
        for (int i = 0; i < doc.size(); i++) send_byte(doc[i], i == doc.size() - 1);
        doc_cnt++;
    endtask

    // Drop valid, wait until every expected transaction is out, then let the
    // pipeline drain bytes that produce no text.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers on back-to-back cycles; only call while idle.
    task automatic set_limits(input logic [CFG_W-1:0] text_lim, input logic [CFG_W-1:0] cap);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= REG_TEXT_LIMIT;
        i_cfg_wdata <= text_lim;
        @(posedge i_clk);
        i_cfg_addr  <= REG_POSITION_CAP;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Append one byte to the document under construction.
    task automatic add_byte(input logic [7:0] c);
        doc = {doc, c};
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    // Text bytes: mostly printable, some from the full range, never '<'.
    task automatic add_text(input int n);
        logic [7:0] c;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) c = 8'($urandom_range(255));
            else c = 8'($urandom_range(32, 126));
            if (c == "<") c = "a";
            add_byte(c);
        end
    endtask

    // Bytes after a closing style or script tag, dropped up to the next '>'.
    task automatic add_tail();
        case ($urandom_range(2))
            0: ;
            1: add_str(">");
            default: begin
                add_text(2);
                add_str(">");
            end
        endcase
    endtask

    // Ordinary tags plus near misses of the tags the parser classifies.
    task automatic add_tag();
        case ($urandom_range(9))
            0: add_str("<p>");
            1: add_str("</p>");
            2: add_str("<div class=\"a\">");
            3: add_str("<br/>");
            4: add_str("<sx>");
            5: add_str("<scr>");
            6: add_str("</bo>");
            7: add_str("</htm>");
            8: add_str("<STYLE>");
            default: add_str("<a href=x>");
        endcase
    endtask

    task automatic add_segment();
        case ($urandom_range(7))
            0, 1, 2: add_text($urandom_range(1, 10));
            3, 4: add_tag();
            5: begin
                add_str("<style>");
                add_text($urandom_range(0, 6));
                if ($urandom_range(1)) add_str("</sty<a");
                add_str("</style>");
                add_tail();
            end
            6: begin
                add_str("<script>");
                add_text($urandom_range(0, 6));
                if ($urandom_range(1)) add_str("if(a<b)</scrip");
                add_str("</script>");
                add_tail();
            end
            default: repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(128, 255)));
        endcase
    endtask

    // Build one document: mostly well-formed pages with random content, some noise.
    task automatic build_doc();
        doc.delete();
        if ($urandom_range(99) < 15) begin
            repeat ($urandom_range(1, 24)) begin
                if ($urandom_range(3) == 0) add_byte("<");
                else add_byte(8'($urandom_range(255)));
            end
        end else begin
            case ($urandom_range(4))
                0: ;
                1: add_str("<html>");
                2: add_str("<html><head><title>x</title></head>");
                3: add_str("<bo<bod");
                default: add_text(3);
            endcase
            add_str("<body");
            if ($urandom_range(1)) add_str(" id=m");
            add_str(">");
            repeat ($urandom_range(1, 6)) add_segment();
            case ($urandom_range(6))
                0, 1, 2: add_str("</body></html>");
                3: add_str("</html>");
                4: ;
                5: add_str("</bo");
                default: add_str("<scr");
            endcase
            add_text($urandom_range(0, 3));
        end
    endtask

    initial begin
        int phase_start;
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_addr    <= REG_TEXT_LIMIT;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: body search, an all-ones and an all-zeros text byte, an
        // unknown tag that shares a prefix with style and script, a closing
        // body tag that stops the text, a trailing byte after the stop that
        // ends the document silently, then a one-byte document with no body.
        doc.delete();
        add_str("<body>");
        add_byte(8'hFF);
        add_str("<s>");
        add_byte(8'h00);
        add_str("</body>z");
        send_doc();
        doc.delete();
        add_byte(8'h00);
        send_doc();

        // Random documents under each register setting, defaults first.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase > 0) begin
                settle();
                case (phase)
                    1: set_limits('0, '1);
                    2: set_limits('1, '0);
                    3: set_limits(CFG_W'(3), CFG_W'(24));
                    4: set_limits(CFG_W'($urandom_range(1, 40)), CFG_W'($urandom_range(10, 90)));
                    5: set_limits('1, '1);
                    default: set_limits(TEXT_LIMIT_RST, POSITION_CAP_RST);
                endcase
            end
            phase_start = sent_cnt;
            while (sent_cnt - phase_start < PHASE_BYTES) begin
                build_doc();
                send_doc();
            end
        end
        settle();

        $display("tb: %0d bytes in %0d documents under %0d register settings, one long stall",
                 sent_cnt, doc_cnt, NUM_PHASES);
        $display("tb: %0d text bytes and %0d end markers compared", char_cnt, end_cnt);
        if (fail_cnt == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
